FILE: rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Page range translation table package
// Sizes, request codes and shared types for the translation table core.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int MAX_ENTRIES       = 1024;
  localparam int DEVICE_PAGE_SHIFT = 16;
  localparam int HOST_PAGE_SHIFT   = 12;

  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W  = 64;
  localparam int WORD_W  = 2 * ADDR_W;
  localparam int EIDX_W  = 10;
  localparam int REQ_W   = 2;
  localparam int IN_W    = 2 * ADDR_W;
  localparam int OUT_W   = 208;

  localparam logic [ADDR_W-1:0] HOST_MASK =
    ~((ADDR_W'(1) << HOST_PAGE_SHIFT) - ADDR_W'(1));

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic lt;
    logic in_range;
  } cmp_res_t;

endpackage

FILE: rtl/core/page_range_translation_table.sv
// ----------------------------------------------------------------------------
// Page range translation table
// Sorted page table with binary-search lookup, sorted insert and clear.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   xlat_addr, map_base                     req_type
// m_axis   out  hit, mapped_addr, entry_index, status,  -
//               lookup_total, hit_total
//
// Lookup: one table read and compare per search step (at most
// log2(entries) + 1 steps); a hit adds the ST_MAP state for the offset add.
// Insert: search steps, then a read state and a write state per entry moved; the
// single RAM port pair moves one entry at a time. Clear and other requests go to ST_DONE.
// Reset is synchronous; the table contents need no clearing.
// One request is in flight; a held result stalls only the final load.
// ----------------------------------------------------------------------------
module page_range_translation_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ptt_pkg::IN_W-1:0]   s_tdata,   // xlat_addr, map_base
  input  logic [ptt_pkg::REQ_W-1:0]  s_tuser,   // req_type
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ptt_pkg::OUT_W-1:0]  m_tdata    // hit, mapped_addr, entry_index,
                                                // status, lookup_total,
                                                // hit_total, zero pad
);
  import ptt_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LOOKUP   = 3'd1;
  localparam logic [2:0] ST_MAP      = 3'd2;
  localparam logic [2:0] ST_INS_SRCH = 3'd3;
  localparam logic [2:0] ST_SHIFT_RD = 3'd4;
  localparam logic [2:0] ST_SHIFT_WR = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0]  state;
  cnt_t        entry_count;
  addr_t       lookup_counter;
  addr_t       hit_counter;
  addr_t       addr_q;
  addr_t       base_q;
  cnt_t        lo;
  cnt_t        hx;
  cnt_t        lo_next;
  cnt_t        hx_next;
  idx_t        mid;
  idx_t        pos;
  idx_t        j;
  addr_t       diff_q;
  addr_t       mbase_q;
  logic        res_hit;
  addr_t       res_mapped;
  idx_t        res_idx;
  logic        res_status;

  logic              accept;
  logic              out_load;
  logic              ram_we;
  idx_t              ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  idx_t              ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  addr_t             diff;
  cmp_res_t          cr;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  ptt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptt_cmp u_cmp (
    .addr  (addr_q),
    .start (ram_rdata[ADDR_W-1:0]),
    .diff  (diff),
    .res   (cr)
  );

  always_comb begin
    lo_next   = lo;
    hx_next   = hx;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = j;
    ram_wdata = ram_rdata;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ram_re = 1'b1;
          if (s_tuser == REQ_LOOKUP) begin
            ram_raddr = IDX_W'((entry_count - CNT_W'(1)) >> 1);
          end else begin
            ram_raddr = IDX_W'(entry_count >> 1);
          end
        end
      end
      ST_LOOKUP: begin
        if (cr.lt) begin
          hx_next = CNT_W'(mid);
        end else if (!cr.in_range) begin
          lo_next = CNT_W'(mid) + CNT_W'(1);
        end
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(lo_next + ((hx_next - lo_next - CNT_W'(1)) >> 1));
      end
      ST_INS_SRCH: begin
        if (cr.lt) begin
          hx_next = CNT_W'(mid);
        end else begin
          lo_next = CNT_W'(mid) + CNT_W'(1);
        end
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(lo_next + ((hx_next - lo_next) >> 1));
      end
      ST_SHIFT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j - IDX_W'(1);
        if (j == pos) begin
          ram_we    = 1'b1;
          ram_wdata = {base_q, addr_q};
        end
      end
      ST_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_count    <= '0;
      lookup_counter <= '0;
      hit_counter    <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            addr_q     <= s_tdata[ADDR_W-1:0];
            base_q     <= s_tdata[IN_W-1:ADDR_W];
            res_hit    <= 1'b0;
            res_mapped <= '0;
            res_idx    <= '0;
            res_status <= (s_tuser == REQ_INSERT) &&
                          (entry_count >= CNT_W'(MAX_ENTRIES));
            lo         <= '0;
            hx         <= entry_count;
            mid        <= ram_raddr;
            pos        <= '0;
            j          <= '0;
            case (s_tuser)
              REQ_LOOKUP: begin
                lookup_counter <= lookup_counter + ADDR_W'(1);
                state <= (entry_count == '0) ? ST_DONE : ST_LOOKUP;
              end
              REQ_INSERT: begin
                if (entry_count >= CNT_W'(MAX_ENTRIES)) begin
                  state      <= ST_DONE;
                end else if (entry_count == '0) begin
                  state <= ST_SHIFT_RD;
                end else begin
                  state <= ST_INS_SRCH;
                end
              end
              REQ_CLEAR: begin
                entry_count <= '0;
                state       <= ST_DONE;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          lo  <= lo_next;
          hx  <= hx_next;
          mid <= ram_raddr;
          if (cr.in_range) begin
            hit_counter <= hit_counter + ADDR_W'(1);
            res_hit     <= 1'b1;
            res_idx     <= mid;
            diff_q      <= diff;
            mbase_q     <= ram_rdata[WORD_W-1:ADDR_W];
            state       <= ST_MAP;
          end else if (lo_next >= hx_next) begin
            state <= ST_DONE;
          end
        end
        ST_MAP: begin
          res_mapped <= mbase_q + (diff_q & HOST_MASK);
          state      <= ST_DONE;
        end
        ST_INS_SRCH: begin
          lo  <= lo_next;
          hx  <= hx_next;
          mid <= ram_raddr;
          if (lo_next == hx_next) begin
            pos   <= lo_next[IDX_W-1:0];
            j     <= entry_count[IDX_W-1:0];
            state <= ST_SHIFT_RD;
          end
        end
        ST_SHIFT_RD: begin
          if (j == pos) begin
            entry_count <= entry_count + CNT_W'(1);
            res_idx     <= pos;
            state       <= ST_DONE;
          end else begin
            state <= ST_SHIFT_WR;
          end
        end
        ST_SHIFT_WR: begin
          j     <= j - IDX_W'(1);
          state <= ST_SHIFT_RD;
        end
        ST_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, hit_counter, lookup_counter, res_status,
                         EIDX_W'(res_idx), res_mapped, res_hit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken while a request is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_lookup_keeps_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP || state == ST_MAP) |=> $stable(entry_count) && !$past(ram_we))
    else $error("table changed during lookup");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_SHIFT_RD || state == ST_SHIFT_WR))
    else $error("table write outside insert");

endmodule

FILE: rtl/core/ptt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ptt_cmp.sv
// ----------------------------------------------------------------------------
// Shared address compare unit
// Subtracts a page start from the request address and classifies the result.
// ----------------------------------------------------------------------------
module ptt_cmp (
  input  ptt_pkg::addr_t    addr,
  input  ptt_pkg::addr_t    start,
  output ptt_pkg::addr_t    diff,
  output ptt_pkg::cmp_res_t res
);
  import ptt_pkg::*;

  assign diff         = addr - start;
  assign res.lt       = addr < start;
  assign res.in_range = !res.lt && (diff[ADDR_W-1:DEVICE_PAGE_SHIFT] == '0);

endmodule
